FILE: src/tlfs_pkg.sv
// shared types, widths and helpers of the two-level feedback scheduler
package tlfs_pkg;

   localparam int MAX_JOBS = 16;
   localparam int IDX_W    = $clog2(MAX_JOBS);
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);
   localparam int ID_W     = 8;
   localparam int WORK_W   = 16;
   localparam int QUANT_W  = 8;
   localparam int TIME_W   = 32;

   localparam logic [QUANT_W-1:0] QUANTUM_RESET = QUANT_W'(4);

   typedef struct packed {
      logic              arrival_valid;
      logic [ID_W-1:0]   arrival_id;
      logic [WORK_W-1:0] arrival_work;
   } req_item_type;

   typedef struct packed {
      logic              busy_res;
      logic [ID_W-1:0]   run_id;
      logic              ran_from_background;
      logic              finished;
      logic [TIME_W-1:0] finish_time;
      logic              demoted;
      logic              arrival_dropped;
   } rsp_item_type;

   // queue update for one time unit
   typedef struct packed {
      logic              push_a;
      logic [ID_W-1:0]   a_id;
      logic [WORK_W-1:0] a_work;
      logic              upd;
      logic [WORK_W-1:0] upd_work;
      logic              pop;
      logic              push_b;
      logic [ID_W-1:0]   b_id;
      logic [WORK_W-1:0] b_work;
   } queue_ctl_type;

   // ring slot at head + offset, offset may be up to MAX_JOBS
   function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] offset);
      logic [CNT_W-1:0] off_m;
      logic [CNT_W:0]   sum;
      off_m = (offset >= CNT_W'(MAX_JOBS)) ? offset - CNT_W'(MAX_JOBS) : offset;
      sum   = (CNT_W+1)'(head) + (CNT_W+1)'(off_m);
      if (sum >= (CNT_W+1)'(MAX_JOBS)) begin
         sum = sum - (CNT_W+1)'(MAX_JOBS);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

FILE: src/tlfs_chan_if.sv
// valid/ready channel interfaces for requests and responses
interface tlfs_req_if;
   import tlfs_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tlfs_rsp_if;
   import tlfs_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/two_level_feedback_scheduler_unit.sv
// top level of the two-level feedback (foreground/background) scheduler
//
// usage
//   req_chan carries one item per time unit: an optional arriving job
//   (arrival_valid, arrival_id, arrival_work). rsp_chan returns one item per
//   request: which job ran, from which queue, finish, demotion, drop, and the
//   wrapping time count at the end of the unit.
//   csr_we/csr_wdata write the quantum; write it only while the block is idle.
//   an accepted item waits in the request register and is processed when the
//   response register is free or being read; its response is valid from then on.
//   throughput: one item per cycle while rsp_chan takes each response; the whole
//   time unit (push, head service, pop, demotion) is one pass of logic between
//   the request register and the response register.
//   a stalled receiver holds the response register; the request register
//   still takes one more item, then req_chan.ready drops until rsp drains.
//   reset (synchronous, active high) empties both queues, clears the time
//   count and the slice counter, and sets the quantum to four. queue entries
//   are not cleared; only written entries are ever read.
module two_level_feedback_scheduler_unit import tlfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   tlfs_req_if.sink           req_chan,
   tlfs_rsp_if.source         rsp_chan,
   input  logic               csr_we,
   input  logic [QUANT_W-1:0] csr_wdata
);

   // request register
   logic               in_valid_ff, in_valid_in;
   req_item_type       in_item_ff;
   // response register
   logic               out_valid_ff, out_valid_in;
   rsp_item_type       out_item_ff;

   logic [QUANT_W-1:0] quantum_ff;
   logic [QUANT_W-1:0] slice_ff, slice_in;
   logic [TIME_W-1:0]  time_ff;

   logic               advance;
   logic               req_take;
   rsp_item_type       result;
   queue_ctl_type      fore_ctl, back_ctl;
   logic [CNT_W-1:0]   fore_count, back_count;
   logic [ID_W-1:0]    fore_id, back_id;
   logic [WORK_W-1:0]  fore_work, back_work;

   // the held item moves on when the response slot is free or being taken
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         quantum_ff   <= QUANTUM_RESET;
         slice_ff     <= '0;
         time_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            quantum_ff <= csr_wdata;
         end
         if (advance) begin
            slice_ff <= slice_in;
            time_ff  <= time_ff + TIME_W'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_chan.payload;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   tlfs_sched u_sched (
      .item       (in_item_ff),
      .quantum    (quantum_ff),
      .slice_used (slice_ff),
      .time_now   (time_ff),
      .fore_count (fore_count),
      .fore_id    (fore_id),
      .fore_work  (fore_work),
      .back_count (back_count),
      .back_id    (back_id),
      .back_work  (back_work),
      .result     (result),
      .fore_ctl   (fore_ctl),
      .back_ctl   (back_ctl),
      .slice_next (slice_in)
   );

   // foreground: round robin with quantum
   tlfs_queue u_fore (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctl       (fore_ctl),
      .head_id   (fore_id),
      .head_work (fore_work),
      .count     (fore_count)
   );

   // background: first come first served
   tlfs_queue u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctl       (back_ctl),
      .head_id   (back_id),
      .head_work (back_work),
      .count     (back_count)
   );

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_item_ff;

`ifndef SYNTH
   a_fore_bound: assert property (@(posedge clock) disable iff (reset)
      fore_count <= CNT_W'(MAX_JOBS))
      else $error("foreground count beyond capacity");

   a_back_bound: assert property (@(posedge clock) disable iff (reset)
      back_count <= CNT_W'(MAX_JOBS))
      else $error("background count beyond capacity");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed item left no response");

   a_time_step: assert property (@(posedge clock) disable iff (reset)
      advance && !$past(reset) |=> time_ff == $past(time_ff) + TIME_W'(1))
      else $error("time count did not advance by one");

   a_idle_only_empty: assert property (@(posedge clock) disable iff (reset)
      advance && !result.busy_res |->
         fore_count == '0 && back_count == '0 && !in_item_ff.arrival_valid)
      else $error("idle unit while a job was queued");
`endif

endmodule

FILE: src/tlfs_queue.sv
// circular job queue with head pointer, fill count and two tail pushes
module tlfs_queue import tlfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  queue_ctl_type     ctl,
   output logic [ID_W-1:0]   head_id,
   output logic [WORK_W-1:0] head_work,
   output logic [CNT_W-1:0]  count
);

   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ID_W-1:0]   ids_ff [MAX_JOBS];
   logic [WORK_W-1:0] work_ff [MAX_JOBS];
   logic [IDX_W-1:0]  slot_a, slot_b;

   // second push lands behind the first one and after a possible pop
   assign slot_a = slot_at(head_ff, count_ff);
   assign slot_b = slot_at(head_ff, count_ff + CNT_W'(ctl.push_a));

   always_comb begin
      head_in  = ctl.pop ? slot_at(head_ff, CNT_W'(1)) : head_ff;
      count_in = count_ff + CNT_W'(ctl.push_a) + CNT_W'(ctl.push_b) - CNT_W'(ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (advance) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // later writes take priority
   always_ff @(posedge clock) begin
      if (advance) begin
         if (ctl.push_a) begin
            ids_ff[slot_a]  <= ctl.a_id;
            work_ff[slot_a] <= ctl.a_work;
         end
         if (ctl.upd) begin
            work_ff[head_ff] <= ctl.upd_work;
         end
         if (ctl.push_b) begin
            ids_ff[slot_b]  <= ctl.b_id;
            work_ff[slot_b] <= ctl.b_work;
         end
      end
   end

   assign head_id   = ids_ff[head_ff];
   assign head_work = work_ff[head_ff];
   assign count     = count_ff;

endmodule

FILE: src/tlfs_sched.sv
// scheduling decision for one time unit
module tlfs_sched import tlfs_pkg::*; (
   input  req_item_type       item,
   input  logic [QUANT_W-1:0] quantum,
   input  logic [QUANT_W-1:0] slice_used,
   input  logic [TIME_W-1:0]  time_now,
   input  logic [CNT_W-1:0]   fore_count,
   input  logic [ID_W-1:0]    fore_id,
   input  logic [WORK_W-1:0]  fore_work,
   input  logic [CNT_W-1:0]   back_count,
   input  logic [ID_W-1:0]    back_id,
   input  logic [WORK_W-1:0]  back_work,
   output rsp_item_type       result,
   output queue_ctl_type      fore_ctl,
   output queue_ctl_type      back_ctl,
   output logic [QUANT_W-1:0] slice_next
);

   logic [QUANT_W-1:0] q_eff;
   logic [QUANT_W:0]   slice_inc;
   logic               arr_push;
   logic               fore_any;
   logic [ID_W-1:0]    f_id;
   logic [WORK_W-1:0]  f_work;
   logic [WORK_W-1:0]  f_left;

   always_comb begin
      q_eff     = (quantum == '0) ? QUANT_W'(1) : quantum;
      slice_inc = (QUANT_W+1)'(slice_used) + (QUANT_W+1)'(1);
      arr_push  = item.arrival_valid && (fore_count != CNT_W'(MAX_JOBS));
      fore_any  = (fore_count != '0) || arr_push;
      // an arrival into an empty foreground becomes the head at once
      f_id      = (fore_count == '0) ? item.arrival_id : fore_id;
      f_work    = (fore_count == '0) ? item.arrival_work : fore_work;
      f_left    = f_work - WORK_W'(1);

      result                     = '0;
      result.finish_time         = time_now + TIME_W'(1);
      result.arrival_dropped     = item.arrival_valid && !arr_push;

      fore_ctl        = '0;
      fore_ctl.push_a = arr_push;
      fore_ctl.a_id   = item.arrival_id;
      fore_ctl.a_work = item.arrival_work;
      fore_ctl.b_id   = f_id;
      fore_ctl.b_work = f_left;
      fore_ctl.upd_work = f_left;

      back_ctl        = '0;
      back_ctl.a_id   = f_id;
      back_ctl.a_work = f_left;
      back_ctl.upd_work = back_work - WORK_W'(1);

      slice_next = slice_used;

      if (fore_any) begin
         result.busy_res = 1'b1;
         result.run_id   = f_id;
         if (f_work <= WORK_W'(1)) begin
            result.finished = 1'b1;
            fore_ctl.pop    = 1'b1;
            slice_next      = '0;
         end else if (slice_inc >= (QUANT_W+1)'(q_eff)) begin
            fore_ctl.pop = 1'b1;
            slice_next   = '0;
            if (back_count != CNT_W'(MAX_JOBS)) begin
               back_ctl.push_a = 1'b1;
               result.demoted  = 1'b1;
            end else begin
               // background full: back to the foreground tail
               fore_ctl.push_b = 1'b1;
            end
         end else begin
            fore_ctl.upd = 1'b1;
            slice_next   = slice_inc[QUANT_W-1:0];
         end
      end else if (back_count != '0) begin
         result.busy_res            = 1'b1;
         result.ran_from_background = 1'b1;
         result.run_id              = back_id;
         if (back_work <= WORK_W'(1)) begin
            result.finished = 1'b1;
            back_ctl.pop    = 1'b1;
         end else begin
            back_ctl.upd = 1'b1;
         end
      end
   end

endmodule
